// ----- sv/tqle_pkg.sv -----
`timescale 1ns / 1ps
package tqle_pkg;
  localparam int NUM_AGENTS = 8;
  localparam int GRID_W = 32;
  localparam int GRID_H = 32;
  localparam int NUM_ACTIONS = 4;
  localparam int DEPTH = NUM_AGENTS * GRID_W * GRID_H * NUM_ACTIONS;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW - 2;
  localparam int QW = 32;
  localparam int VW = 16;
  localparam int DW = 50;
  localparam logic signed [9:0] R_MINE = 10'sd100;
  localparam logic signed [9:0] R_SUPER = -10'sd500;
  localparam logic signed [9:0] R_VISITED = -10'sd200;
  localparam logic signed [9:0] R_PLAIN = -10'sd100;
  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_MINE = 2'd1;
  localparam logic [1:0] HIT_SUPER = 2'd2;
  localparam logic [1:0] HIT_OTHER = 2'd3;
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_SELECT = 1'b1;
  localparam logic [0:0] REG_EXPLORE = 1'b0;
  localparam logic [0:0] REG_DISCOUNT = 1'b1;
  localparam logic [15:0] EXPLORE_RESET = 16'd6554;
  localparam logic [15:0] DISCOUNT_RESET = 16'd58982;
endpackage

// ----- sv/tqle_ram.sv -----
`timescale 1ns / 1ps
module tqle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/tqle_div.sv -----
`timescale 1ns / 1ps
module tqle_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic signed [tqle_pkg::DW-1:0] num,
  input  logic [16:0]                    den,
  output logic                           done,
  output logic signed [tqle_pkg::DW-1:0] quo
);
  localparam int W = tqle_pkg::DW;
  logic [W-1:0] q;
  logic [16:0] r;
  logic [16:0] d;
  logic neg, act;
  logic [5:0] cnt;
  logic [17:0] rs;
  always_comb rs = {r, q[W-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        act <= 1'b1;
        cnt <= 6'(W - 1);
        neg <= num[W-1];
        q <= num[W-1] ? W'(-num) : W'(num);
        r <= '0;
        d <= den;
      end else if (act) begin
        if (rs >= {1'b0, d}) begin
          r <= 17'(rs - {1'b0, d});
          q <= {q[W-2:0], 1'b1};
        end else begin
          r <= rs[16:0];
          q <= {q[W-2:0], 1'b0};
        end
        if (cnt == 6'd0) begin
          act <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end
  always_comb quo = neg ? -$signed(q) : $signed(q);
endmodule

// ----- sv/tabular_q_learning_engine_unit.sv -----
`timescale 1ns / 1ps
// Tabular Q-learning engine, eight agents on a 32x32 grid, four actions per cell.
// Input: assert start with the item fields while busy is low; the word is taken
// at that edge and busy rises until the result has been issued.
// Output: done pulses for one cycle with chosen_action, q_value and reward.
// A select reads the four actions of a cell from the Q memory, one per cycle,
// then picks the action and raises done.
// An update scans the four visit counts of the previous cell, the four Q values
// of the next cell and the target entry, forms the target, then runs a 50-step
// restoring divider for the learning step and then raises done.
// Items are handled one at a time; busy falls with done and holds off the next.
// Configuration: wr_en, wr_index, wr_data write explore_threshold (0) or
// discount_gain (1) at any edge.
// Reset: rst clears the registers to defaults, then a clearing pass over all 32768
// entries zeroes both memories while busy stays high.
// The receiver cannot stall: done is a single-cycle strobe.
module tabular_q_learning_engine_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              req_type,
  input  logic [2:0]        agent,
  input  logic [4:0]        cell_x,
  input  logic [4:0]        cell_y,
  input  logic [1:0]        taken_action,
  input  logic [1:0]        hit_type,
  input  logic [4:0]        next_x,
  input  logic [4:0]        next_y,
  input  logic [15:0]       explore_draw,
  input  logic [1:0]        random_action,
  input  logic [1:0]        tie_draw,
  input  logic              wr_en,
  input  logic              wr_index,
  input  logic [15:0]       wr_data,
  output logic              done,
  output logic [1:0]        chosen_action,
  output logic signed [31:0] q_value,
  output logic signed [9:0] reward
);
  localparam int AW = tqle_pkg::AW;
  localparam int CW = tqle_pkg::CW;
  localparam int DW = tqle_pkg::DW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCANV, S_SCANN, S_READQ, S_MUL, S_DGO, S_DWAIT, S_WRITE,
    S_SCANS, S_PICK
  } state_t;
  state_t state;

  logic [15:0] explore_threshold, discount_gain;
  logic        rq;
  logic [1:0]  act, hit, rnd, tie;
  logic [15:0] draw;
  logic [CW-1:0] cbase, nbase;
  logic [AW-1:0] clr;
  logic [2:0]  k;
  logic        pend;
  logic [1:0]  pidx;
  logic signed [31:0] best, qs [4];
  logic        visited;
  logic signed [9:0] r;
  logic [15:0] vcur;
  logic signed [31:0] qcur;
  logic signed [48:0] prod;
  logic signed [DW-1:0] delta;
  logic [1:0]  pick;
  logic [2:0]  cntt;
  logic [1:0]  rank;

  logic q_we, v_we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] q_wd, q_rd;
  logic [15:0] v_wd, v_rd;

  tqle_ram #(.WIDTH(32), .DEPTH(tqle_pkg::DEPTH)) u_q (
    .clk, .we(q_we), .waddr, .wdata(q_wd), .raddr, .rdata(q_rd));
  tqle_ram #(.WIDTH(16), .DEPTH(tqle_pkg::DEPTH)) u_v (
    .clk, .we(v_we), .waddr, .wdata(v_wd), .raddr, .rdata(v_rd));

  logic dgo, ddone;
  logic signed [DW-1:0] quo;
  tqle_div u_div (.clk, .rst, .go(dgo), .num(delta), .den({1'b0, vcur} + 17'd1),
    .done(ddone), .quo);

  logic signed [DW-1:0] nq;
  logic signed [31:0] nqs;
  always_comb begin
    nq = DW'(qcur) + quo;
    if (nq > DW'(32'sh7fffffff)) nqs = 32'sh7fffffff;
    else if (nq < -DW'(64'sh80000000)) nqs = 32'sh80000000;
    else nqs = nq[31:0];
  end

  logic signed [DW-1:0] rnd_prod;
  always_comb rnd_prod = DW'((prod + 49'sd32768) >>> 16);

  always_comb begin
    logic [2:0] c;
    logic [1:0] s;
    c = 3'd0;
    for (int i = 0; i < 4; i++) if (qs[i] == best) c = c + 3'd1;
    cntt = c;
    rank = (c == 3'd3) ? ((tie == 2'd3) ? 2'd0 : tie) :
           (c == 3'd4) ? tie : (c == 3'd2) ? {1'b0, tie[0]} : 2'd0;
    pick = 2'd0;
    s = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (qs[i] == best) begin
        if (2'(c - 3'd1) - s == rank) pick = 2'(i);
        s = s + 2'd1;
      end
    end
  end

  always_comb begin
    q_we = 1'b0;
    v_we = 1'b0;
    waddr = clr;
    q_wd = '0;
    v_wd = '0;
    raddr = {cbase, k[1:0]};
    dgo = (state == S_DGO);
    if (state == S_CLEAR) begin
      q_we = 1'b1;
      v_we = 1'b1;
    end else if (state == S_WRITE) begin
      q_we = 1'b1;
      v_we = 1'b1;
      waddr = {cbase, act};
      q_wd = nqs;
      v_wd = (vcur == 16'hffff) ? vcur : vcur + 16'd1;
    end
    if (state == S_SCANN) raddr = {nbase, k[1:0]};
    else if (state == S_READQ) raddr = {cbase, act};
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      done <= 1'b0;
      pend <= 1'b0;
      explore_threshold <= tqle_pkg::EXPLORE_RESET;
      discount_gain <= tqle_pkg::DISCOUNT_RESET;
    end else begin
      done <= 1'b0;
      if (wr_en) begin
        if (wr_index == tqle_pkg::REG_EXPLORE) explore_threshold <= wr_data;
        else discount_gain <= wr_data;
      end
      pend <= 1'b0;
      pidx <= k[1:0];
      unique case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(tqle_pkg::DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            rq <= req_type; act <= taken_action; hit <= hit_type;
            rnd <= random_action; tie <= tie_draw; draw <= explore_draw;
            cbase <= {agent, cell_y, cell_x};
            nbase <= {agent, next_y, next_x};
            k <= 3'd0;
            visited <= 1'b0;
            state <= (req_type == tqle_pkg::REQ_SELECT) ? S_SCANS : S_SCANV;
          end
        end
        S_SCANV: begin
          if (k != 3'd4) begin k <= k + 3'd1; pend <= 1'b1; end
          if (pend && v_rd != 16'd0) visited <= 1'b1;
          if (k == 3'd4 && !pend) begin k <= 3'd0; state <= S_SCANN; end
        end
        S_SCANN, S_SCANS: begin
          if (k != 3'd4) begin k <= k + 3'd1; pend <= 1'b1; end
          if (pend) begin
            qs[pidx] <= $signed(q_rd);
            if (pidx == 2'd0 || $signed(q_rd) > best) best <= $signed(q_rd);
          end
          if (k == 3'd4 && !pend) begin
            state <= (state == S_SCANS) ? S_PICK : S_READQ;
            pend <= (state == S_SCANN);
          end
        end
        S_PICK: begin
          done <= 1'b1;
          chosen_action <= (draw < explore_threshold) ? rnd : pick;
          q_value <= best;
          reward <= '0;
          state <= S_IDLE;
        end
        S_READQ: begin
          if (!pend) begin
            qcur <= $signed(q_rd);
            vcur <= v_rd;
            prod <= $signed({1'b0, discount_gain}) * best;
            unique case (hit)
              tqle_pkg::HIT_MINE: r <= tqle_pkg::R_MINE;
              tqle_pkg::HIT_SUPER: r <= tqle_pkg::R_SUPER;
              tqle_pkg::HIT_NONE: r <= visited ? tqle_pkg::R_VISITED : tqle_pkg::R_PLAIN;
              default: r <= tqle_pkg::R_PLAIN;
            endcase
            state <= S_MUL;
          end
        end
        S_MUL: begin
          delta <= (DW'(r) <<< 16) + rnd_prod - DW'(qcur);
          state <= S_DGO;
        end
        S_DGO: state <= S_DWAIT;
        S_DWAIT: if (ddone) state <= S_WRITE;
        S_WRITE: begin
          done <= 1'b1;
          chosen_action <= act;
          q_value <= nqs;
          reward <= r;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("start not taken");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");
  a_select_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rq == tqle_pkg::REQ_SELECT) |-> reward == 10'sd0)
    else $error("select reward nonzero");
  a_cnt_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK) |-> cntt != 3'd0) else $error("no best action");
`endif
endmodule

// ----- bench/tb_tabular_q_learning_engine_unit.sv -----
`timescale 1ns / 1ps
module tb_tabular_q_learning_engine_unit;

  localparam int         STALL_LIMIT = 100000;

  typedef struct {
    logic        req_type;
    logic [2:0]  agent;
    logic [4:0]  cell_x;
    logic [4:0]  cell_y;
    logic [1:0]  taken_action;
    logic [1:0]  hit_type;
    logic [4:0]  next_x;
    logic [4:0]  next_y;
    logic [15:0] explore_draw;
    logic [1:0]  random_action;
    logic [1:0]  tie_draw;
  } word_t;

  typedef struct {
    logic [1:0]         action;
    logic signed [31:0] q;
    logic signed [9:0]  rew;
  } answer_t;

  logic clk, rst, start, busy, done;
  logic req_type;
  logic [2:0] agent;
  logic [4:0] cell_x, cell_y, next_x, next_y;
  logic [1:0] taken_action, hit_type, random_action, tie_draw;
  logic [15:0] explore_draw;
  logic wr_en, wr_index;
  logic [15:0] wr_data;
  logic [1:0] chosen_action;
  logic signed [31:0] q_value;
  logic signed [9:0] reward;

  tabular_q_learning_engine_unit dut (.*);

  logic signed [31:0] q_table [tqle_pkg::DEPTH];
  logic [15:0]        visit_count [tqle_pkg::DEPTH];
  logic [15:0]        epsilon;
  logic [15:0]        gamma;
  answer_t            pending_answers [$];
  int                 idle_pct;
  int                 errors;
  int                 quiet_cycles;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic int cell_base(logic [2:0] a, logic [4:0] x, logic [4:0] y);
    return ((int'(a) * tqle_pkg::GRID_H + int'(y)) * tqle_pkg::GRID_W + int'(x))
           * tqle_pkg::NUM_ACTIONS;
  endfunction

  function automatic logic signed [31:0] best_q(int base);
    logic signed [31:0] m;
    m = q_table[base];
    for (int i = 1; i < tqle_pkg::NUM_ACTIONS; i++)
      if (q_table[base + i] > m) m = q_table[base + i];
    return m;
  endfunction

  function automatic answer_t learn_or_pick(word_t w);
    answer_t r;
    int base, nbase, idx, cnt, rank, seen;
    logic signed [31:0] best;
    longint t, target, nq;
    logic visited;
    base = cell_base(w.agent, w.cell_x, w.cell_y);
    r.rew = '0;
    if (w.req_type == tqle_pkg::REQ_SELECT) begin
      best = best_q(base);
      r.q = best;
      if (w.explore_draw < epsilon) begin
        r.action = w.random_action;
      end else begin
        cnt = 0;
        for (int i = 0; i < tqle_pkg::NUM_ACTIONS; i++) if (q_table[base + i] == best) cnt++;
        rank = int'(w.tie_draw) % cnt;
        seen = 0;
        r.action = '0;
        for (int i = tqle_pkg::NUM_ACTIONS - 1; i >= 0; i--) begin
          if (q_table[base + i] == best) begin
            if (cnt - 1 - seen == rank) r.action = 2'(i);
            seen++;
          end
        end
      end
    end else begin
      idx = base + int'(w.taken_action);
      nbase = cell_base(w.agent, w.next_x, w.next_y);
      case (w.hit_type)
        tqle_pkg::HIT_MINE:  r.rew = tqle_pkg::R_MINE;
        tqle_pkg::HIT_SUPER: r.rew = tqle_pkg::R_SUPER;
        tqle_pkg::HIT_OTHER: r.rew = tqle_pkg::R_PLAIN;
        default: begin
          visited = 1'b0;
          for (int i = 0; i < tqle_pkg::NUM_ACTIONS; i++)
            if (visit_count[base + i] != 0) visited = 1'b1;
          r.rew = visited ? tqle_pkg::R_VISITED : tqle_pkg::R_PLAIN;
        end
      endcase
      t = longint'(gamma) * longint'(best_q(nbase)) + 32768;
      t = (t >= 0) ? t / 65536 : -((-t + 65535) / 65536);
      target = longint'(r.rew) * 65536 + t;
      nq = longint'(q_table[idx])
         + (target - longint'(q_table[idx])) / (longint'(visit_count[idx]) + 1);
      if (nq > 64'sd2147483647) nq = 64'sd2147483647;
      if (nq < -64'sd2147483648) nq = -64'sd2147483648;
      q_table[idx] = 32'(nq);
      if (visit_count[idx] != 16'hFFFF) visit_count[idx] = visit_count[idx] + 1'b1;
      r.action = w.taken_action;
      r.q = q_table[idx];
    end
    return r;
  endfunction

  task automatic send_word(word_t w);
    req_type <= w.req_type;
    agent <= w.agent;
    cell_x <= w.cell_x;
    cell_y <= w.cell_y;
    taken_action <= w.taken_action;
    hit_type <= w.hit_type;
    next_x <= w.next_x;
    next_y <= w.next_y;
    explore_draw <= w.explore_draw;
    random_action <= w.random_action;
    tie_draw <= w.tie_draw;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_answers = {pending_answers, learn_or_pick(w)};
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    drain();
    repeat (80) @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    if (idx == tqle_pkg::REG_EXPLORE) epsilon = val;
    else gamma = val;
    wr_en <= 1'b0;
  endtask

  function automatic word_t make_word(logic rt, logic [2:0] a, logic [4:0] x, logic [4:0] y,
                                      logic [1:0] act, logic [1:0] hit, logic [4:0] nx,
                                      logic [4:0] ny, logic [15:0] draw, logic [1:0] ra,
                                      logic [1:0] td);
    word_t w;
    w.req_type = rt; w.agent = a; w.cell_x = x; w.cell_y = y;
    w.taken_action = act; w.hit_type = hit; w.next_x = nx; w.next_y = ny;
    w.explore_draw = draw; w.random_action = ra; w.tie_draw = td;
    return w;
  endfunction

  function automatic word_t random_word(bit wide);
    word_t w;
    w.req_type = ($urandom_range(0, 99) < 40) ? tqle_pkg::REQ_SELECT : tqle_pkg::REQ_UPDATE;
    w.agent = 3'($urandom_range(0, 7));
    w.cell_x = wide ? 5'($urandom) : 5'($urandom_range(0, 3));
    w.cell_y = wide ? 5'($urandom) : 5'($urandom_range(0, 3));
    w.next_x = wide ? 5'($urandom) : 5'($urandom_range(0, 3));
    w.next_y = wide ? 5'($urandom) : 5'($urandom_range(0, 3));
    w.taken_action = 2'($urandom);
    w.hit_type = 2'($urandom);
    w.explore_draw = 16'($urandom);
    w.random_action = 2'($urandom);
    w.tie_draw = 2'($urandom);
    return w;
  endfunction

  task automatic test_directed;
    idle_pct = 0;
    for (int i = 0; i < 4; i++)
      send_word(make_word(tqle_pkg::REQ_SELECT, 3'd7, 5'd31, 5'd31, 2'd0,
                          tqle_pkg::HIT_NONE, 5'd0, 5'd0, 16'hFFFF, 2'd0, 2'(i)));
    send_word(make_word(tqle_pkg::REQ_SELECT, 3'd0, 5'd0, 5'd0, 2'd0,
                        tqle_pkg::HIT_NONE, 5'd0, 5'd0, 16'd0, 2'd3, 2'd0));
    send_word(make_word(tqle_pkg::REQ_SELECT, 3'd0, 5'd0, 5'd0, 2'd0,
                        tqle_pkg::HIT_NONE, 5'd0, 5'd0, 16'd6553, 2'd2, 2'd0));
    send_word(make_word(tqle_pkg::REQ_SELECT, 3'd0, 5'd0, 5'd0, 2'd0,
                        tqle_pkg::HIT_NONE, 5'd0, 5'd0, 16'd6554, 2'd2, 2'd1));
    send_word(make_word(tqle_pkg::REQ_UPDATE, 3'd1, 5'd2, 5'd3, 2'd1,
                        tqle_pkg::HIT_NONE, 5'd4, 5'd4, 16'd0, 2'd0, 2'd0));
    send_word(make_word(tqle_pkg::REQ_UPDATE, 3'd1, 5'd2, 5'd3, 2'd2,
                        tqle_pkg::HIT_NONE, 5'd4, 5'd4, 16'd0, 2'd0, 2'd0));
    send_word(make_word(tqle_pkg::REQ_UPDATE, 3'd1, 5'd4, 5'd4, 2'd0,
                        tqle_pkg::HIT_MINE, 5'd4, 5'd4, 16'd0, 2'd0, 2'd0));
    send_word(make_word(tqle_pkg::REQ_UPDATE, 3'd1, 5'd2, 5'd3, 2'd3,
                        tqle_pkg::HIT_SUPER, 5'd4, 5'd4, 16'd0, 2'd0, 2'd0));
    send_word(make_word(tqle_pkg::REQ_UPDATE, 3'd1, 5'd2, 5'd3, 2'd1,
                        tqle_pkg::HIT_OTHER, 5'd4, 5'd4, 16'd0, 2'd0, 2'd0));
    send_word(make_word(tqle_pkg::REQ_UPDATE, 3'd1, 5'd2, 5'd3, 2'd1,
                        tqle_pkg::HIT_MINE, 5'd2, 5'd3, 16'd0, 2'd0, 2'd0));
    send_word(make_word(tqle_pkg::REQ_UPDATE, 3'd7, 5'd31, 5'd31, 2'd3,
                        tqle_pkg::HIT_MINE, 5'd31, 5'd31, 16'hFFFF, 2'd3, 2'd3));
    send_word(make_word(tqle_pkg::REQ_UPDATE, 3'd7, 5'd31, 5'd31, 2'd2,
                        tqle_pkg::HIT_MINE, 5'd31, 5'd31, 16'hFFFF, 2'd3, 2'd3));
    for (int i = 0; i < 4; i++)
      send_word(make_word(tqle_pkg::REQ_SELECT, 3'd7, 5'd31, 5'd31, 2'd0,
                          tqle_pkg::HIT_NONE, 5'd0, 5'd0, 16'hFFFF, 2'd0, 2'(i)));
    send_word(make_word(tqle_pkg::REQ_SELECT, 3'd1, 5'd2, 5'd3, 2'd0,
                        tqle_pkg::HIT_NONE, 5'd0, 5'd0, 16'h8000, 2'd0, 2'd3));
  endtask

  task automatic test_random(int count, int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      send_word(random_word($urandom_range(0, 9) == 0));
      if ($urandom_range(0, 99) == 0) begin
        start <= 1'b0;
        drain();
      end
    end
    start <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected word: chosen_action %0d q_value %0d reward %0d",
               chosen_action, q_value, reward);
        errors++;
      end else begin
        automatic answer_t e = pending_answers.pop_front();
        if (chosen_action !== e.action) begin
          $error("chosen_action expected %0d actual %0d", e.action, chosen_action);
          errors++;
        end
        if (q_value !== e.q) begin
          $error("q_value expected %0d actual %0d", e.q, q_value);
          errors++;
        end
        if (reward !== e.rew) begin
          $error("reward expected %0d actual %0d", e.rew, reward);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tabular_q_learning_engine_unit: mismatch");
      $finish;
    end
  end

  initial begin
    errors = 0;
    quiet_cycles = 0;
    idle_pct = 0;
    rst <= 1'b1;
    start <= 1'b0;
    wr_en <= 1'b0;
    wr_index <= tqle_pkg::REG_EXPLORE;
    wr_data <= '0;
    req_type <= tqle_pkg::REQ_UPDATE;
    agent <= '0; cell_x <= '0; cell_y <= '0; next_x <= '0; next_y <= '0;
    taken_action <= '0; hit_type <= tqle_pkg::HIT_NONE; explore_draw <= '0;
    random_action <= '0; tie_draw <= '0;
    for (int i = 0; i < tqle_pkg::DEPTH; i++) begin
      q_table[i] = '0;
      visit_count[i] = '0;
    end
    epsilon = tqle_pkg::EXPLORE_RESET;
    gamma = tqle_pkg::DISCOUNT_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(200, 0);
    write_reg(tqle_pkg::REG_EXPLORE, 16'd0);
    write_reg(tqle_pkg::REG_DISCOUNT, 16'd0);
    test_random(200, 87);
    write_reg(tqle_pkg::REG_EXPLORE, 16'hFFFF);
    write_reg(tqle_pkg::REG_DISCOUNT, 16'hFFFF);
    test_random(190, 12);
    write_reg(tqle_pkg::REG_EXPLORE, 16'($urandom));
    write_reg(tqle_pkg::REG_DISCOUNT, 16'($urandom));
    test_random(190, 50);
    drain();
    repeat (80) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0)
      $display("tabular_q_learning_engine_unit: match");
    else
      $display("tabular_q_learning_engine_unit: mismatch");
    $finish;
  end
endmodule

// ----- files.f -----
sv/tqle_pkg.sv
sv/tqle_ram.sv
sv/tqle_div.sv
sv/tabular_q_learning_engine_unit.sv
bench/tb_tabular_q_learning_engine_unit.sv
